// File: hw/rtl/nuf_pkg.sv
// ----------------------------------------------------------------------------
// nuf_pkg
// Shared types and constants for the NAL unit fragmenter.
// ----------------------------------------------------------------------------
package nuf_pkg;

  localparam int unsigned LENGTH_BITS = 24;
  localparam int unsigned MAX_BITS    = 16;
  localparam int unsigned NUM_RES     = 4;
  localparam int unsigned CNT_BITS    = $clog2(NUM_RES + 1);

  localparam logic [MAX_BITS-1:0] MAX_PKT_RESET = 16'd1400;
  localparam logic [MAX_BITS-1:0] MAX_PKT_FLOOR = 16'd8;

  // header sizes in bytes (payload header + FU header)
  localparam logic [MAX_BITS-1:0] HDR_SIZE_H264 = 16'd2;
  localparam logic [MAX_BITS-1:0] HDR_SIZE_H265 = 16'd3;

  localparam logic [4:0] FU_A_TYPE    = 5'd28;
  localparam logic [5:0] FU_TYPE_H265 = 6'd49;

  typedef enum logic [0:0] {
    REG_CODEC   = 1'b0,
    REG_MAX_PKT = 1'b1
  } cfg_reg_e;

  // position within the NAL header bytes of a fragmented unit
  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_BODY   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       pkt_end;
    logic       unit_end;
  } res_t;

  typedef struct packed {
    logic                valid;
    logic [CNT_BITS-1:0] cnt;
    res_t [NUM_RES-1:0]  res;
  } res_bundle_t;

endpackage

// File: hw/rtl/nuf_core.sv
// ----------------------------------------------------------------------------
// nuf_core
// Input register, unit state and per-byte result generation.
// ----------------------------------------------------------------------------
module nuf_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             unit_start_i,
  input  logic [nuf_pkg::LENGTH_BITS-1:0]  unit_length_i,
  input  logic                             cfg_valid_i,
  input  logic [0:0]                       cfg_index_i,
  input  logic [nuf_pkg::MAX_BITS-1:0]     cfg_data_i,
  input  logic                             take_i,
  output nuf_pkg::res_bundle_t             bundle_o
);
  import nuf_pkg::*;

  // input register
  logic                   s1_valid_q;
  logic [7:0]             s1_byte_q;
  logic                   s1_start_q;
  logic [LENGTH_BITS-1:0] s1_len_q;

  // configuration
  logic                codec_h264_q;
  logic [MAX_BITS-1:0] max_pkt_q;

  // unit state
  logic [LENGTH_BITS-1:0] bytes_left_q, bytes_left_d;
  logic [MAX_BITS-1:0]    frag_fill_q, frag_fill_d;
  logic                   fragmenting_q, fragmenting_d;
  phase_e                 phase_q, phase_d;
  logic [7:0]             hdr_first_q, hdr_first_d;
  logic [7:0]             hdr_second_q, hdr_second_d;
  logic [7:0]             fu_hdr_q, fu_hdr_d;

  logic                   advance;
  logic [MAX_BITS-1:0]    eff_max, hdr_size;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] bl;
  logic [MAX_BITS-1:0]    ff;
  logic                   frag;
  phase_e                 ph;
  logic [MAX_BITS:0]      ff_inc;
  logic                   last, pe, e_bit;
  logic [CNT_BITS-1:0]    n;
  res_t [NUM_RES-1:0]     res;
  logic [7:0]             h265_ph0;

  assign advance    = s1_valid_q && take_i;
  assign in_ready_o = !s1_valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q  <= data_byte_i;
      s1_start_q <= unit_start_i;
      s1_len_q   <= unit_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_h264_q <= 1'b0;
      max_pkt_q    <= MAX_PKT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CODEC:   codec_h264_q <= cfg_data_i[0];
        REG_MAX_PKT: max_pkt_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_max  = (max_pkt_q < MAX_PKT_FLOOR) ? MAX_PKT_FLOOR : max_pkt_q;
  assign hdr_size = codec_h264_q ? HDR_SIZE_H264 : HDR_SIZE_H265;
  assign len      = (s1_len_q == '0) ? LENGTH_BITS'(1) : s1_len_q;

  always_comb begin
    // a new unit start overrides whatever was left of the old one
    bl   = s1_start_q ? len : bytes_left_q;
    ff   = s1_start_q ? '0 : frag_fill_q;
    frag = s1_start_q ? (len > LENGTH_BITS'(eff_max)) : fragmenting_q;
    ph   = s1_start_q ? PH_FIRST : phase_q;

    bytes_left_d  = bl;
    frag_fill_d   = ff;
    fragmenting_d = frag;
    phase_d       = ph;
    hdr_first_d   = hdr_first_q;
    hdr_second_d  = hdr_second_q;
    fu_hdr_d      = fu_hdr_q;

    n      = '0;
    res    = '0;
    last   = (bl == LENGTH_BITS'(1));
    ff_inc = '0;
    pe     = 1'b0;
    e_bit  = 1'b0;
    h265_ph0 = {hdr_first_q[7], FU_TYPE_H265, hdr_first_q[0]};

    if (bl != '0) begin
      bytes_left_d = bl - LENGTH_BITS'(1);
      if (!frag) begin
        res[0] = '{data: s1_byte_q, pkt_end: last, unit_end: last};
        n      = CNT_BITS'(1);
      end else begin
        unique case (ph)
          PH_FIRST: begin
            hdr_first_d = s1_byte_q;
            if (codec_h264_q) begin
              fu_hdr_d    = {3'b100, s1_byte_q[4:0]};
              res[0]      = '{data: {s1_byte_q[7:5], FU_A_TYPE}, pkt_end: 1'b0,
                              unit_end: 1'b0};
              res[1]      = '{data: {3'b100, s1_byte_q[4:0]}, pkt_end: 1'b0,
                              unit_end: 1'b0};
              n           = CNT_BITS'(2);
              frag_fill_d = HDR_SIZE_H264;
              phase_d     = PH_BODY;
            end else begin
              phase_d = PH_SECOND;
            end
          end
          PH_SECOND: begin
            hdr_second_d = s1_byte_q;
            fu_hdr_d     = {2'b10, hdr_first_q[6:1]};
            res[0]       = '{data: h265_ph0, pkt_end: 1'b0, unit_end: 1'b0};
            res[1]       = '{data: s1_byte_q, pkt_end: 1'b0, unit_end: 1'b0};
            res[2]       = '{data: {2'b10, hdr_first_q[6:1]}, pkt_end: 1'b0,
                             unit_end: 1'b0};
            n            = CNT_BITS'(3);
            frag_fill_d  = HDR_SIZE_H265;
            phase_d      = PH_BODY;
          end
          PH_BODY: begin
            if (ff == '0) begin
              // new fragment: repeat the payload header, E bit on the final one
              e_bit = (bl <= LENGTH_BITS'(eff_max - hdr_size));
              if (codec_h264_q) begin
                res[0] = '{data: {hdr_first_q[7:5], FU_A_TYPE}, pkt_end: 1'b0,
                           unit_end: 1'b0};
                res[1] = '{data: {1'b0, e_bit, fu_hdr_q[5:0]}, pkt_end: 1'b0,
                           unit_end: 1'b0};
                ff_inc = {1'b0, HDR_SIZE_H264} + 17'd1;
                pe     = last || (ff_inc >= {1'b0, eff_max});
                res[2] = '{data: s1_byte_q, pkt_end: pe, unit_end: last};
                n      = CNT_BITS'(3);
              end else begin
                res[0] = '{data: h265_ph0, pkt_end: 1'b0, unit_end: 1'b0};
                res[1] = '{data: hdr_second_q, pkt_end: 1'b0, unit_end: 1'b0};
                res[2] = '{data: {1'b0, e_bit, fu_hdr_q[5:0]}, pkt_end: 1'b0,
                           unit_end: 1'b0};
                ff_inc = {1'b0, HDR_SIZE_H265} + 17'd1;
                pe     = last || (ff_inc >= {1'b0, eff_max});
                res[3] = '{data: s1_byte_q, pkt_end: pe, unit_end: last};
                n      = CNT_BITS'(4);
              end
            end else begin
              ff_inc = {1'b0, ff} + 17'd1;
              pe     = last || (ff_inc >= {1'b0, eff_max});
              res[0] = '{data: s1_byte_q, pkt_end: pe, unit_end: last};
              n      = CNT_BITS'(1);
            end
            frag_fill_d = pe ? '0 : ff_inc[MAX_BITS-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q  <= '0;
      frag_fill_q   <= '0;
      fragmenting_q <= 1'b0;
      phase_q       <= PH_FIRST;
    end else if (advance) begin
      bytes_left_q  <= bytes_left_d;
      frag_fill_q   <= frag_fill_d;
      fragmenting_q <= fragmenting_d;
      phase_q       <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hdr_first_q  <= hdr_first_d;
      hdr_second_q <= hdr_second_d;
      fu_hdr_q     <= fu_hdr_d;
    end
  end

  assign bundle_o.valid = s1_valid_q;
  assign bundle_o.cnt   = n;
  assign bundle_o.res   = res;

endmodule

// File: hw/rtl/nuf_out_buf.sv
// ----------------------------------------------------------------------------
// nuf_out_buf
// Result register holding one request's bytes, drained one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module nuf_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nuf_pkg::res_bundle_t bundle_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 packet_end_o,
  output logic                 unit_end_o,
  output logic                 run_last_o
);
  import nuf_pkg::*;

  res_t [NUM_RES-1:0]  entries_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic                pop, load;

  assign pop    = out_valid_o && out_ready_i;
  // free now, or the last entry leaves this cycle
  assign take_o = (cnt_q == '0) || ((cnt_q == CNT_BITS'(1)) && out_ready_i);
  assign load   = bundle_i.valid && take_o && (bundle_i.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= bundle_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entries_q <= bundle_i.res;
    end else if (pop) begin
      for (int i = 0; i < NUM_RES - 1; i++) begin
        entries_q[i] <= entries_q[i+1];
      end
    end
  end

  assign out_valid_o  = (cnt_q != '0);
  assign out_byte_o   = entries_q[0].data;
  assign packet_end_o = entries_q[0].pkt_end;
  assign unit_end_o   = entries_q[0].unit_end;
  assign run_last_o   = (cnt_q == CNT_BITS'(1));

endmodule

// File: hw/rtl/nal_unit_fragmenter.sv
// ----------------------------------------------------------------------------
// nal_unit_fragmenter
// Splits NAL units into RTP packets or H.264 / H.265 fragmentation units.
// ----------------------------------------------------------------------------
// Path: the results of a byte pass through the input register, then the result
//   register, before they are offered on the output.
// Throughput: one input byte per cycle for plain bytes while the receiver is
//   ready; a byte that starts a fragment yields 2 to 4 result bytes, and the input
//   stalls until all but the last of them have left the output.
// Reset: unit state cleared, codec H.265, max packet 1400; buffer empty.
module nal_unit_fragmenter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             unit_start_i,
  input  logic [nuf_pkg::LENGTH_BITS-1:0]  unit_length_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       out_byte_o,
  output logic                             packet_end_o,
  output logic                             unit_end_o,
  output logic                             run_last_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [0:0]                       cfg_index_i,
  input  logic [nuf_pkg::MAX_BITS-1:0]     cfg_data_i
);
  import nuf_pkg::*;

  res_bundle_t bundle;
  logic        take;

  assign cfg_ready_o = 1'b1;

  nuf_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .unit_start_i  (unit_start_i),
    .unit_length_i (unit_length_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .take_i        (take),
    .bundle_o      (bundle)
  );

  nuf_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bundle_i     (bundle),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .packet_end_o (packet_end_o),
    .unit_end_o   (unit_end_o),
    .run_last_o   (run_last_o)
  );

  // a loaded request is always visible on the output next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bundle.valid && take && (bundle.cnt != '0)) |=> out_valid_o)
    else $error("loaded results not presented");

  // the end of a unit always closes its packet
  a_unit_end_pkt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && unit_end_o) |-> packet_end_o)
    else $error("unit end without packet end");

  // a request never yields more results than the buffer holds
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bundle.valid |-> (bundle.cnt <= CNT_BITS'(NUM_RES)))
    else $error("result count out of range");

endmodule

// File: tb/fragment_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fragment_checker
// Watches the byte, output and register channels of the NAL unit fragmenter,
// predicts each output byte and compares it field by field.
// ----------------------------------------------------------------------------
module fragment_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [7:0]                      data_byte_i,
  input  logic                            unit_start_i,
  input  logic [nuf_pkg::LENGTH_BITS-1:0] unit_length_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [7:0]                      out_byte_i,
  input  logic                            packet_end_i,
  input  logic                            unit_end_i,
  input  logic                            run_last_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [0:0]                      cfg_index_i,
  input  logic [nuf_pkg::MAX_BITS-1:0]    cfg_data_i,
  output int                              fail_cnt_o,
  output int                              pending_o
);
  import nuf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       pkt_end;
    logic       unit_end;
    logic       run_last;
  } frag_byte_t;

  frag_byte_t predicted_bytes[$];
  frag_byte_t run_bytes[$];

  logic                codec_h264;
  logic [MAX_BITS-1:0] max_pkt;
  int                  bytes_left;
  int                  fill;
  logic                fragmenting;
  phase_e              phase;
  logic [7:0]          hdr_first;
  logic [7:0]          hdr_second;
  logic [7:0]          fu_hdr;

  task automatic report(input string field, input int got, input int want);
    $display("mismatch on %s: got 0x%0h, expected 0x%0h", field, got, want);
    fail_cnt_o++;
  endtask

  task automatic push_out(input logic [7:0] b, input logic pe, input logic ue);
    frag_byte_t r;
    r.data     = b;
    r.pkt_end  = pe;
    r.unit_end = ue;
    r.run_last = 1'b0;
    run_bytes.insert(run_bytes.size(), r);
  endtask

  // bytes produced for one accepted input byte, appended to predicted_bytes
  task automatic fragment_byte(input logic [7:0] b, input logic st,
                               input logic [LENGTH_BITS-1:0] len);
    int         m;
    int         hs;
    logic       e;
    logic       last;
    logic       pe;
    frag_byte_t r;
    m  = (max_pkt < MAX_PKT_FLOOR) ? int'(MAX_PKT_FLOOR) : int'(max_pkt);
    hs = codec_h264 ? int'(HDR_SIZE_H264) : int'(HDR_SIZE_H265);
    run_bytes.delete();
    if (st) begin
      bytes_left  = (len == '0) ? 1 : int'(len);
      phase       = PH_FIRST;
      fill        = 0;
      fragmenting = (bytes_left > m);
    end
    if (bytes_left == 0) return;

    if (!fragmenting) begin
      last = (bytes_left == 1);
      push_out(b, last, last);
    end else if (phase == PH_FIRST) begin
      hdr_first = b;
      if (codec_h264) begin
        fu_hdr = {3'b100, b[4:0]};
        push_out({b[7:5], FU_A_TYPE}, 1'b0, 1'b0);
        push_out(fu_hdr, 1'b0, 1'b0);
        fill  = 2;
        phase = PH_BODY;
      end else begin
        // H.265 headers need the second byte
        phase = PH_SECOND;
      end
    end else if (phase == PH_SECOND) begin
      hdr_second = b;
      fu_hdr     = {2'b10, hdr_first[6:1]};
      push_out({hdr_first[7], FU_TYPE_H265, hdr_first[0]}, 1'b0, 1'b0);
      push_out(b, 1'b0, 1'b0);
      push_out(fu_hdr, 1'b0, 1'b0);
      fill  = 3;
      phase = PH_BODY;
    end else begin
      if (fill == 0) begin
        // E bit only when the rest of the unit fits in this fragment
        e = (bytes_left <= m - hs);
        if (hs == 2) begin
          push_out({hdr_first[7:5], FU_A_TYPE}, 1'b0, 1'b0);
        end else begin
          push_out({hdr_first[7], FU_TYPE_H265, hdr_first[0]}, 1'b0, 1'b0);
          push_out(hdr_second, 1'b0, 1'b0);
        end
        push_out({1'b0, e, fu_hdr[5:0]}, 1'b0, 1'b0);
        fill = hs;
      end
      fill++;
      last = (bytes_left == 1);
      pe   = last || (fill >= m);
      push_out(b, pe, last);
      if (pe) fill = 0;
    end
    bytes_left--;

    if (run_bytes.size() > 0) begin
      r = run_bytes[run_bytes.size() - 1];
      r.run_last = 1'b1;
      run_bytes[run_bytes.size() - 1] = r;
    end
    foreach (run_bytes[i]) predicted_bytes.insert(predicted_bytes.size(), run_bytes[i]);
  endtask

  task automatic check_out();
    frag_byte_t want;
    if (predicted_bytes.size() == 0) begin
      report("out_byte with nothing pending", out_byte_i, 0);
    end else begin
      want = predicted_bytes[0];
      predicted_bytes.delete(0);
      if (out_byte_i !== want.data) report("out_byte", out_byte_i, want.data);
      if (packet_end_i !== want.pkt_end) report("packet_end", packet_end_i, want.pkt_end);
      if (unit_end_i !== want.unit_end) report("unit_end", unit_end_i, want.unit_end);
      if (run_last_i !== want.run_last) report("run_last", run_last_i, want.run_last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_h264  = 1'b0;
      max_pkt     = MAX_PKT_RESET;
      bytes_left  = 0;
      fill        = 0;
      fragmenting = 1'b0;
      phase       = PH_FIRST;
      predicted_bytes.delete();
      fail_cnt_o  = 0;
      pending_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_out();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_CODEC:   codec_h264 = cfg_data_i[0];
          REG_MAX_PKT: max_pkt    = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) fragment_byte(data_byte_i, unit_start_i, unit_length_i);
      pending_o = predicted_bytes.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives NAL unit bytes and register writes into the fragmenter with bursty
// requests and a stalling receiver; fragment_checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import nuf_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             data_byte = '0;
  logic                   unit_start = 1'b0;
  logic [LENGTH_BITS-1:0] unit_length = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             out_byte;
  logic                   packet_end;
  logic                   unit_end;
  logic                   run_last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [0:0]             cfg_index = '0;
  logic [MAX_BITS-1:0]    cfg_data = '0;

  int fail_cnt;
  int pending;

  int burst_left = 0;
  bit gaps_on = 1'b1;
  int cur_max = 1400;
  bit unit_open = 1'b0;
  int unit_items;

  int rx_mode = 0;
  int mode_left = 0;
  int tick = 0;

  nal_unit_fragmenter u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .data_byte_i   (data_byte),
    .unit_start_i  (unit_start),
    .unit_length_i (unit_length),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_byte_o    (out_byte),
    .packet_end_o  (packet_end),
    .unit_end_o    (unit_end),
    .run_last_o    (run_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  fragment_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .data_byte_i   (data_byte),
    .unit_start_i  (unit_start),
    .unit_length_i (unit_length),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_byte_i    (out_byte),
    .packet_end_i  (packet_end),
    .unit_end_i    (unit_end),
    .run_last_i    (run_last),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver: always ready, coin toss, or a periodic stall, switching now and then
  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = $urandom_range(0, 2);
      mode_left = $urandom_range(16, 96);
    end
    mode_left--;
    tick++;
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ((tick % 7) >= 3);
    endcase
  end

  // one byte request; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic st,
                           input logic [LENGTH_BITS-1:0] len);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid    <= 1'b1;
    data_byte   <= b;
    unit_start  <= st;
    unit_length <= len;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [MAX_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MAX_PKT) cur_max = (val < MAX_PKT_FLOOR) ? int'(MAX_PKT_FLOOR) : int'(val);
    @(negedge clk);
  endtask

  // drain all pending output, then allow for bytes that produce nothing
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic send_unit(input int len_field, input int nbytes, input int split_at);
    for (int i = 0; i < nbytes; i++) begin
      if (i == split_at) begin
        // max size change in the middle of an open unit
        settle();
        write_reg(REG_MAX_PKT, MAX_BITS'($urandom_range(8, 40)));
      end
      send_byte(8'($urandom_range(0, 255)), i == 0,
                (i == 0) ? LENGTH_BITS'(len_field) : LENGTH_BITS'($urandom()));
    end
  endtask

  task automatic random_unit();
    int m;
    int len;
    int nbytes;
    int split;
    int pick;
    m     = cur_max;
    pick  = $urandom_range(0, 99);
    split = -1;
    if (pick < 8 && !unit_open) begin
      // stray bytes with no unit open
      repeat ($urandom_range(1, 3)) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, LENGTH_BITS'($urandom()));
      end
      return;
    end
    if (pick < 20) begin
      // abandoned unit, restarted by the next one
      len    = $urandom_range(2, 24'hFF_FFFF);
      nbytes = $urandom_range(1, (m > 64) ? 40 : 2 * m + 4);
      if (nbytes >= len) nbytes = len - 1;
      unit_open = 1'b1;
    end else begin
      if (pick < 25) len = $urandom_range(0, 1);
      else if (m > 64) len = $urandom_range(2, 40);
      else len = $urandom_range(2, 3 * m);
      nbytes    = (len == 0) ? 1 : len;
      unit_open = 1'b0;
      if (pick >= 92 && m <= 64 && len >= 6) split = $urandom_range(2, len - 2);
    end
    send_unit(len, nbytes, split);
    unit_items += nbytes;
  endtask

  initial begin
    int mx;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: H.265, 1400 bytes; stray byte, zero length, short unit
    send_byte(8'hA5, 1'b0, 24'hFF_FFFF);
    send_byte(8'h00, 1'b1, 24'd0);
    send_byte(8'hFF, 1'b1, 24'd2);
    send_byte(8'h00, 1'b0, 24'd0);

    // H.264 at the smallest size: one fragmented unit, then an abandoned one
    settle();
    write_reg(REG_CODEC, 16'd1);
    write_reg(REG_MAX_PKT, 16'd8);
    send_byte(8'hFF, 1'b1, 24'd9);
    for (int i = 1; i < 9; i++) begin
      send_byte(i[0] ? 8'h00 : 8'hFF, 1'b0, LENGTH_BITS'($urandom()));
    end
    send_byte(8'h7C, 1'b1, 24'hFF_FFFF);
    send_byte(8'h3C, 1'b0, 24'd0);

    // H.265, size below the floor; restart right after the header byte
    settle();
    write_reg(REG_CODEC, 16'd0);
    write_reg(REG_MAX_PKT, 16'd3);
    send_byte(8'h40, 1'b1, 24'd20);
    send_byte(8'hFF, 1'b1, 24'd12);
    send_byte(8'h01, 1'b0, LENGTH_BITS'($urandom()));
    for (int i = 2; i < 5; i++) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0, LENGTH_BITS'($urandom()));
    end
    // grow the limit mid-fragment: unit ends inside it without the E bit
    settle();
    write_reg(REG_MAX_PKT, 16'hFFFF);
    for (int i = 5; i < 12; i++) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0, LENGTH_BITS'($urandom()));
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0, 1:    mx = 8;
        2, 3:    mx = $urandom_range(9, 40);
        4, 5:    mx = 16'hFFFF;
        6:       mx = 0;
        default: mx = $urandom_range(8, 24);
      endcase
      settle();
      write_reg(REG_CODEC, (p % 2 == 0) ? 16'd1 : 16'd0);
      write_reg(REG_MAX_PKT, MAX_BITS'(mx));
      gaps_on    = (p % 3 != 1);
      unit_items = 0;
      while (unit_items < 30) random_unit();
    end

    settle();
    if (fail_cnt == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
